// ===== src/mck_pkg.sv =====
// Package for the Morse character keyer: segment codes, controller/datapath
// command and status structs, and the character code table.
// No dependencies.
package mck_pkg;

    // Lower-case letters sit this far above their upper-case forms.
    localparam logic [7:0] CASE_FOLD  = 8'h20;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [9:0] UNIT_RESET = 10'd200;

    // Kind of segment that the datapath places in its output register.
    typedef logic [1:0] t_seg;
    localparam t_seg SEG_ELEM  = 2'd0;  // dot or dash, key on
    localparam t_seg SEG_GAP   = 2'd1;  // one-unit gap after an element
    localparam t_seg SEG_SPACE = 2'd2;  // four-unit word gap
    localparam t_seg SEG_END   = 2'd3;  // two-unit closing gap, marked last

    // Code of one character: element count and dash mask, first element
    // in bit 0. A zero count means the character has no elements.
    typedef struct packed {
        logic       is_space;
        logic [2:0] len;
        logic [4:0] pat;
    } t_code;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // latch the decoded input character
        logic emit;   // load a segment into the output register
        t_seg seg;    // which segment to load
        logic shift;  // step to the next element
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       out_free;   // output register can take a beat
        logic       in_space;   // input character is a space
        logic [2:0] in_len;     // element count of the input character
        logic       last_elem;  // current element is the final one
    } t_dp_sts;

    // Folds case and looks up the Morse code of one character byte.
    function automatic t_code mck_lookup(input logic [7:0] c_in);
        logic [7:0] c;
        t_code      code;
        c = c_in;
        if (c_in >= 8'h61 && c_in <= 8'h7A) begin
            c = c_in - CASE_FOLD;
        end
        code.is_space = (c == CHAR_SPACE);
        unique case (c)
            8'h41: {code.len, code.pat} = {3'd2, 5'b00010}; // A
            8'h42: {code.len, code.pat} = {3'd4, 5'b00001}; // B
            8'h43: {code.len, code.pat} = {3'd4, 5'b00101}; // C
            8'h44: {code.len, code.pat} = {3'd3, 5'b00001}; // D
            8'h45: {code.len, code.pat} = {3'd1, 5'b00000}; // E
            8'h46: {code.len, code.pat} = {3'd4, 5'b00100}; // F
            8'h47: {code.len, code.pat} = {3'd3, 5'b00011}; // G
            8'h48: {code.len, code.pat} = {3'd4, 5'b00000}; // H
            8'h49: {code.len, code.pat} = {3'd2, 5'b00000}; // I
            8'h4A: {code.len, code.pat} = {3'd4, 5'b01110}; // J
            8'h4B: {code.len, code.pat} = {3'd3, 5'b00101}; // K
            8'h4C: {code.len, code.pat} = {3'd4, 5'b00010}; // L
            8'h4D: {code.len, code.pat} = {3'd2, 5'b00011}; // M
            8'h4E: {code.len, code.pat} = {3'd2, 5'b00001}; // N
            8'h4F: {code.len, code.pat} = {3'd3, 5'b00111}; // O
            8'h50: {code.len, code.pat} = {3'd4, 5'b00110}; // P
            8'h51: {code.len, code.pat} = {3'd4, 5'b01011}; // Q
            8'h52: {code.len, code.pat} = {3'd3, 5'b00010}; // R
            8'h53: {code.len, code.pat} = {3'd3, 5'b00000}; // S
            8'h54: {code.len, code.pat} = {3'd1, 5'b00001}; // T
            8'h55: {code.len, code.pat} = {3'd3, 5'b00100}; // U
            8'h56: {code.len, code.pat} = {3'd4, 5'b01000}; // V
            8'h57: {code.len, code.pat} = {3'd3, 5'b00110}; // W
            8'h58: {code.len, code.pat} = {3'd4, 5'b01001}; // X
            8'h59: {code.len, code.pat} = {3'd4, 5'b01101}; // Y
            8'h5A: {code.len, code.pat} = {3'd4, 5'b00011}; // Z
            8'h30: {code.len, code.pat} = {3'd5, 5'b11111}; // 0
            8'h31: {code.len, code.pat} = {3'd5, 5'b11110}; // 1
            8'h32: {code.len, code.pat} = {3'd5, 5'b11100}; // 2
            8'h33: {code.len, code.pat} = {3'd5, 5'b11000}; // 3
            8'h34: {code.len, code.pat} = {3'd5, 5'b10000}; // 4
            8'h35: {code.len, code.pat} = {3'd5, 5'b00000}; // 5
            8'h36: {code.len, code.pat} = {3'd5, 5'b00001}; // 6
            8'h37: {code.len, code.pat} = {3'd5, 5'b00011}; // 7
            8'h38: {code.len, code.pat} = {3'd5, 5'b00111}; // 8
            8'h39: {code.len, code.pat} = {3'd5, 5'b01111}; // 9
            default: {code.len, code.pat} = {3'd0, 5'b00000};
        endcase
        return code;
    endfunction

endpackage

// ===== src/morse_character_keyer.sv =====
// Top level of the Morse character keyer: joins the controller and datapath.
// Depends on mck_pkg, mck_ctrl and mck_datapath.
//
// Takes one character byte per input beat and sends its Morse keying as a run
// of segment beats, each a key state and a duration in milliseconds (a
// multiple of the unit register, reset 200). Letters (either case) and digits
// give one key-on beat per element (dot one unit, dash three) each followed by
// a one-unit gap; a space gives a four-unit gap; every character, unknown ones
// included, closes with a two-unit gap that carries tlast. While walking a
// character the controller emits one segment per cycle into the single output
// register whenever that register is free; input is taken only between
// characters, though a closing beat may still wait in the output register
// when the next character is accepted. Write the unit register only while
// the block is idle.
module morse_character_keyer
    import mck_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [9:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] key_on, [12:1] duration_ms, [15:13] zero
    output logic        m_axis_tlast
);

    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic        w_key_on;
    logic [11:0] w_duration_ms;

    mck_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mck_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_char        (s_axis_tdata),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_key_on      (w_key_on),
        .o_duration_ms (w_duration_ms),
        .o_last        (m_axis_tlast)
    );

    // Pack the output beat, key state in the lowest bit.
    assign m_axis_tdata = {3'b000, w_duration_ms, w_key_on};

endmodule

// ===== src/mck_datapath.sv =====
// Datapath of the Morse character keyer: unit register, character element
// shifter, duration scaling and the output beat register.
// Depends on mck_pkg.
module mck_datapath
    import mck_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [9:0]  i_cfg_wr_data,
    input  logic [7:0]  i_char,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_key_on,
    output logic [11:0] o_duration_ms,
    output logic        o_last
);

    logic [9:0]  r_unit;
    logic [4:0]  r_pat;
    logic [2:0]  r_cnt;
    logic        r_valid;
    logic        r_key;
    logic [11:0] r_dur;
    logic        r_last;
    t_code       w_code;
    logic [11:0] w_u1;
    logic [11:0] n_dur;
    logic        n_key;
    logic        n_last;

    // Decode the character offered on the input side.
    assign w_code = mck_lookup(i_char);

    // Unit length register; write it only while idle (the block does not enforce it).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_unit <= i_cfg_wr_data;
        end
    end

    // Element pattern and remaining count of the character being keyed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pat <= w_code.pat;
            r_cnt <= w_code.len;
        end else if (i_cmd.shift) begin
            r_pat <= {1'b0, r_pat[4:1]};
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // Segment key state and duration as a small multiple of the unit.
    assign w_u1 = {2'b00, r_unit};
    always_comb begin
        n_key  = 1'b0;
        n_last = 1'b0;
        unique case (i_cmd.seg)
            SEG_ELEM: begin
                n_key = 1'b1;
                n_dur = r_pat[0] ? (w_u1 + {w_u1[10:0], 1'b0}) : w_u1;
            end
            SEG_GAP: begin
                n_dur = w_u1;
            end
            SEG_SPACE: begin
                n_dur = {w_u1[9:0], 2'b00};
            end
            SEG_END: begin
                n_dur  = {w_u1[10:0], 1'b0};
                n_last = 1'b1;
            end
            default: begin
                n_dur = w_u1;
            end
        endcase
    end

    // Output beat register: holds a segment until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_key  <= n_key;
            r_dur  <= n_dur;
            r_last <= n_last;
        end
    end

    assign o_sts.out_free  = !r_valid || i_out_ready;
    assign o_sts.in_space  = w_code.is_space;
    assign o_sts.in_len    = w_code.len;
    assign o_sts.last_elem = (r_cnt == 3'd1);

    assign o_out_valid   = r_valid;
    assign o_key_on      = r_key;
    assign o_duration_ms = r_dur;
    assign o_last        = r_last;

endmodule

// ===== src/mck_ctrl.sv =====
// Controller of the Morse character keyer: walks one character through its
// elements, gaps and closing gap, one segment per free output slot.
// Depends on mck_pkg.
module mck_ctrl
    import mck_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ELEM  = 3'd1;
    localparam logic [2:0] ST_GAP   = 3'd2;
    localparam logic [2:0] ST_SPACE = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.emit  = 1'b0;
        o_cmd.seg   = SEG_END;
        o_cmd.shift = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_space) begin
                        n_state = ST_SPACE;
                    end else if (i_sts.in_len != 3'd0) begin
                        n_state = ST_ELEM;
                    end else begin
                        n_state = ST_END;
                    end
                end
            end
            ST_ELEM: begin
                o_cmd.seg = SEG_ELEM;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_GAP;
                end
            end
            ST_GAP: begin
                o_cmd.seg = SEG_GAP;
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.last_elem ? ST_END : ST_ELEM;
                end
            end
            ST_SPACE: begin
                o_cmd.seg = SEG_SPACE;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_END;
                end
            end
            ST_END: begin
                o_cmd.seg = SEG_END;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/mck_checker.sv =====
// Port-level checker for the Morse character keyer, bound to the top level.
// Depends on morse_character_keyer's port list only.
module mck_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled output beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output beat changed while stalled");

    // After taking a character the keyer is not ready in the cycle after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accepting a character");

    // The closing gap of a character is always key off.
    a_last_is_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[0])
        else $error("closing segment has key on");

    // Padding bits of an output beat are zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:13] == 3'b000))
        else $error("output padding bits not zero");

endmodule

bind morse_character_keyer mck_checker u_mck_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for morse_character_keyer: a clocked driver and monitor
// with random idling on both sides, checked against an in-bench keying predictor.
// Depends on mck_pkg and morse_character_keyer.
`timescale 1ns / 100ps

module tb_top;
    import mck_pkg::*;

    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_Z  = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7A;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;

    // One pending character and the idle cycles that precede its offer.
    typedef struct {
        logic [7:0] code;
        int         gap;
    } t_char_item;

    // One keying segment as it leaves the block.
    typedef struct packed {
        logic        key_on;
        logic [11:0] dur;
        logic        last;
    } t_seg_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [9:0]  i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] char_code
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [0] key_on, [12:1] duration_ms, [15:13] zero
    logic        m_axis_tlast;

    t_char_item char_q[$];
    t_seg_beat  seg_expect_q[$];
    logic [9:0] unit_now = UNIT_RESET;
    int         err_count = 0;
    int         gap_left = 0;
    bit         gap_armed = 1'b0;
    int         stall_left = 0;
    bit         sink_idle_on = 1'b0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;

    string letter_pat [26] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
    };
    string digit_pat [10] = '{
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    morse_character_keyer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Appends one segment with its duration scaled by the current unit.
    task automatic push_seg(input logic key, input int units, input logic last);
        t_seg_beat seg;
        seg.key_on = key;
        seg.dur    = 12'(unit_now * units);
        seg.last   = last;
        seg_expect_q.push_back(seg);
    endtask

    // Works out the whole keying of one character and queues it.
    task automatic push_char_segments(input logic [7:0] c_in);
        logic [7:0] c;
        string      pat;
        c   = c_in;
        pat = "";
        if (c >= CH_LA && c <= CH_LZ) begin
            c = c - CASE_FOLD;
        end
        if (c >= CH_A && c <= CH_Z) begin
            pat = letter_pat[c - CH_A];
        end else if (c >= CH_0 && c <= CH_9) begin
            pat = digit_pat[c - CH_0];
        end else if (c == CHAR_SPACE) begin
            push_seg(1'b0, 4, 1'b0);
        end
        for (int i = 0; i < pat.len(); i++) begin
            push_seg(1'b1, (pat[i] == "-") ? 3 : 1, 1'b0);
            push_seg(1'b0, 1, 1'b0);
        end
        push_seg(1'b0, 2, 1'b1);
    endtask

    task automatic report_mismatch(input string what, input t_seg_beat want,
                                   input t_seg_beat got);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t: %s: expected key=%0b dur=%0d last=%0b, got key=%0b dur=%0d last=%0b",
                     $realtime, what, want.key_on, want.dur, want.last,
                     got.key_on, got.dur, got.last);
        end
    endtask

    // Character driver: offers queued characters, predicting each accepted beat.
    always @(posedge i_clk) begin : char_driver
        logic       offer;
        t_char_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_armed = 1'b0;
        end else begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                push_char_segments(s_axis_tdata);
                offer = 1'b0;
            end
            if (!offer && char_q.size() > 0) begin
                if (!gap_armed) begin
                    gap_left  = char_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    item = char_q.pop_front();
                    s_axis_tdata <= item.code;
                    offer     = 1'b1;
                    gap_armed = 1'b0;
                end
            end
            s_axis_tvalid <= offer;
        end
    end

    // Long receiver hold-off, counted here so the sink side only looks at it.
    always @(posedge i_clk) begin : sink_hold
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Segment monitor: checks each output beat and stalls at random between beats.
    always @(posedge i_clk) begin : seg_monitor
        t_seg_beat got;
        t_seg_beat want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.key_on = m_axis_tdata[0];
                got.dur    = m_axis_tdata[12:1];
                got.last   = m_axis_tlast;
                if (seg_expect_q.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected beat", want, got);
                end else begin
                    want = seg_expect_q.pop_front();
                    if (got !== want) begin
                        report_mismatch("segment mismatch", want, got);
                    end
                end
                stall_left = sink_idle_on ? int'($urandom_range(0, 19)) : 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Mostly well-formed text in either case, with some arbitrary bytes mixed in.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return CH_A + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? CASE_FOLD : 8'h00);
        end else if (r < 72) begin
            return CH_0 + 8'($urandom_range(0, 9));
        end else if (r < 82) begin
            return CHAR_SPACE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_char(input logic [7:0] code, input bit src_idle);
        t_char_item item;
        item.code = code;
        item.gap  = src_idle ? int'($urandom_range(0, 19)) : 0;
        char_q.push_back(item);
    endtask

    // Waits until every character has been taken and every segment has come out.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (char_q.size() != 0 || s_axis_tvalid || seg_expect_q.size() != 0);
    endtask

    task automatic write_unit(input logic [9:0] value);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        unit_now = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit src_idle, input bit snk_idle);
        @(posedge i_clk);
        sink_idle_on <= snk_idle;
        @(negedge i_clk);
        for (int i = 0; i < count; i++) begin
            queue_char(pick_char(), src_idle);
        end
        wait_drained();
    endtask

    initial begin : stimulus
        static logic [7:0] directed [23] = '{
            8'h41, 8'h7A, 8'h30, 8'h39, 8'h35, 8'h45, 8'h54, 8'h51, 8'h59,
            CHAR_SPACE, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h40, 8'h5B, 8'h60,
            8'h7B, 8'h2F, 8'h3A, 8'h6D, 8'h68, 8'h31
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_idle_on <= 1'b1;

        // Directed characters at the reset unit.
        @(negedge i_clk);
        foreach (directed[i]) begin
            queue_char(directed[i], 1'b1);
        end
        wait_drained();

        write_unit(10'd1023);
        run_random(40, 1'b1, 1'b1);

        // Shortest nonzero unit with no idling on either side.
        write_unit(10'd1);
        run_random(40, 1'b0, 1'b0);

        // A zero unit makes every duration zero.
        write_unit(10'd0);
        run_random(20, 1'b1, 1'b0);

        // Receiver holds off while the sender keeps offering back to back.
        write_unit(10'($urandom_range(1, 1023)));
        @(posedge i_clk);
        sink_idle_on <= 1'b0;
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        @(negedge i_clk);
        for (int i = 0; i < 30; i++) begin
            queue_char(pick_char(), 1'b0);
        end
        wait_drained();

        write_unit(10'($urandom_range(1, 1023)));
        run_random(60, 1'b1, 1'b1);

        write_unit(UNIT_RESET);
        run_random(40, 1'b0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
